@@ hw/rtl/criticality_bandwidth_budget_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the criticality bandwidth budget block
// Each macro expands to one labelled concurrent assertion on clock/reset.
// ---------------------------------------------------------------------------
`ifndef CRITICALITY_BANDWIDTH_BUDGET_TOP_ASSERT_SVH
`define CRITICALITY_BANDWIDTH_BUDGET_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define CBB_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high
`define CBB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

@@ hw/rtl/cbb_pkg.sv @@
// ---------------------------------------------------------------------------
// cbb_pkg
// Widths, constants, register indexes and the bucket budget table.
// ---------------------------------------------------------------------------
package cbb_pkg;

   localparam int NUM_CLASSES_DEF = 5;
   localparam int NUM_BUCKETS_DEF = 10;

   localparam int CLASS_W  = 3;
   localparam int COUNT_W  = 32;
   localparam int TOTAL_W  = 35;
   localparam int BUDGET_W = 17;
   localparam int SCALE_W  = 9;
   localparam int NUM_SCALE = 4;
   localparam int CSR_IDX_W = 2;
   localparam int BUCKET_IDX_W = 4;
   localparam int DIFF_W = 17;
   localparam int MUL_W  = 19;
   localparam int PROD_W = DIFF_W + MUL_W;
   localparam int SCALED_W = BUDGET_W + SCALE_W;

   localparam logic [TOTAL_W-1:0]  LOW_EDGE   = 35'd400;
   localparam logic [TOTAL_W-1:0]  HIGH_EDGE  = 35'd100000;
   localparam logic [MUL_W-1:0]    BUCKET_MUL = 19'd388003;
   localparam logic [BUDGET_W-1:0] BUDGET_MAX = 17'd100000;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_CLASS0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_CLASS1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_CLASS2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_CLASS3 = 2'd3;

   localparam logic [SCALE_W-1:0] SCALE0_RST = 9'd64;
   localparam logic [SCALE_W-1:0] SCALE1_RST = 9'd128;
   localparam logic [SCALE_W-1:0] SCALE2_RST = 9'd192;
   localparam logic [SCALE_W-1:0] SCALE3_RST = 9'd256;

   // Command from the sequencer to the count store
   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic [CLASS_W-1:0] addr;
      logic [COUNT_W-1:0] wr_data;
   } mem_cmd_type;

   // Budget of each bucket; buckets past the tenth hold the smallest budget
   function automatic logic [BUDGET_W-1:0] bucket_budget(input logic [BUCKET_IDX_W-1:0] idx);
      logic [BUDGET_W-1:0] b;
      case (idx)
         4'd0:    b = 17'd100000;
         4'd1:    b = 17'd50000;
         4'd2:    b = 17'd25000;
         4'd3:    b = 17'd10000;
         4'd4:    b = 17'd5000;
         4'd5:    b = 17'd1000;
         4'd6:    b = 17'd750;
         4'd7:    b = 17'd500;
         4'd8:    b = 17'd250;
         default: b = 17'd100;
      endcase
      return b;
   endfunction

endpackage

@@ hw/rtl/cbb_req_if.sv @@
// ---------------------------------------------------------------------------
// cbb_req_if
// Request channel: one period's access count from one criticality class.
// ---------------------------------------------------------------------------
interface cbb_req_if;
   import cbb_pkg::*;

   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] criticality_class;
   logic [COUNT_W-1:0] access_count;

   modport source (output valid, output criticality_class, output access_count, input ready);
   modport sink   (input valid, input criticality_class, input access_count, output ready);
endinterface

@@ hw/rtl/cbb_rsp_if.sv @@
// ---------------------------------------------------------------------------
// cbb_rsp_if
// Result channel: budget for the next period and the running system total.
// ---------------------------------------------------------------------------
interface cbb_rsp_if;
   import cbb_pkg::*;

   logic                valid;
   logic                ready;
   logic [BUDGET_W-1:0] next_budget;
   logic                budget_valid;
   logic [TOTAL_W-1:0]  system_total;

   modport source (output valid, output next_budget, output budget_valid,
                   output system_total, input ready);
   modport sink   (input valid, input next_budget, input budget_valid,
                   input system_total, output ready);
endinterface

@@ hw/rtl/cbb_count_store.sv @@
// ---------------------------------------------------------------------------
// cbb_count_store
// Per-class count memory, registered read, valid bit per entry.
// ---------------------------------------------------------------------------
module cbb_count_store #(
   parameter int NUM_CLASSES = cbb_pkg::NUM_CLASSES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cbb_pkg::mem_cmd_type        cmd,
   output logic [cbb_pkg::COUNT_W-1:0] old_count
);
   import cbb_pkg::*;

   localparam int ADDR_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   logic [COUNT_W-1:0]     mem_ff [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] valid_ff;
   logic [COUNT_W-1:0]     rd_data_ff;
   logic                   rd_valid_ff;
   logic [ADDR_W-1:0]      addr;

   assign addr = cmd.addr[ADDR_W-1:0];

   // Write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[addr] <= cmd.wr_data;
      end
   end

   // Mark written entries; reset makes every entry read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff  <= mem_ff[addr];
         rd_valid_ff <= valid_ff[addr];
      end
   end

   assign old_count = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ hw/rtl/criticality_bandwidth_budget_top.sv @@
// ---------------------------------------------------------------------------
// criticality_bandwidth_budget_top
// Per-class bus-access budget from the running system access total.
// ---------------------------------------------------------------------------
// Usage:
//  req_ch carries one request per core per period: its criticality class and
//  the accesses it counted. rsp_ch returns one result per request: the scaled
//  budget for the next period, whether a budget applies, and the system total
//  after the update. csr_* writes the four Q8 class scale registers while idle.
//  The sequencer steps through count-memory read, count write-back with
//  total update, bucket multiply, and scale multiply. A new request is taken
//  once the previous one has reached the result register, even while that
//  result still waits. If the receiver stalls with a result held, the last
//  step waits and req_ch.ready stays low until the result register frees.
//  Reset: synchronous; clears all class counts (through per-entry valid
//  bits, no clearing pass), the total and the result valid flag, and loads
//  the scale reset values. The block is ready once reset is released.
// ---------------------------------------------------------------------------
module criticality_bandwidth_budget_top #(
   parameter int NUM_CLASSES = cbb_pkg::NUM_CLASSES_DEF,
   parameter int NUM_BUCKETS = cbb_pkg::NUM_BUCKETS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   cbb_req_if.sink                       req_ch,
   cbb_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [cbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cbb_pkg::SCALE_W-1:0]   csr_wr_data
);
   import cbb_pkg::*;

   localparam logic [CLASS_W:0]   CLASS_LIMIT = (CLASS_W+1)'(NUM_CLASSES);
   localparam logic [CLASS_W-1:0] CLASS_TOP   = CLASS_W'(NUM_CLASSES - 1);
   localparam logic [BUCKET_IDX_W-1:0] BUCKET_LAST = BUCKET_IDX_W'(NUM_BUCKETS - 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_UPD   = 4'b0010,
      S_MAP   = 4'b0100,
      S_SCALE = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [SCALE_W-1:0]  scale_ff [NUM_SCALE];
   logic [CLASS_W-1:0]  cls_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic                in_range_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                le_low_ff;
   logic                ge_high_ff;
   logic                rsp_valid_ff;
   logic [BUDGET_W-1:0] rsp_budget_ff;
   logic                rsp_bvalid_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;

   logic                accept;
   logic                rsp_free;
   logic                req_in_range;
   mem_cmd_type         mem_cmd;
   logic [COUNT_W-1:0]  old_count;
   logic [TOTAL_W-1:0]  total_in;
   logic [DIFF_W-1:0]   diff;
   logic [BUCKET_IDX_W-1:0] raw_idx;
   logic [BUCKET_IDX_W-1:0] idx;
   logic [SCALE_W-1:0]  scale_sel;
   logic [SCALED_W-1:0] scaled;
   logic [SCALED_W-9:0] shifted;
   logic [BUDGET_W-1:0] budget_sat;

   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_in_range = {1'b0, req_ch.criticality_class} < CLASS_LIMIT;
   assign req_ch.ready = (state_ff == S_IDLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff[0] <= SCALE0_RST;
         scale_ff[1] <= SCALE1_RST;
         scale_ff[2] <= SCALE2_RST;
         scale_ff[3] <= SCALE3_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SCALE_CLASS0: scale_ff[0] <= csr_wr_data;
            CSR_SCALE_CLASS1: scale_ff[1] <= csr_wr_data;
            CSR_SCALE_CLASS2: scale_ff[2] <= csr_wr_data;
            CSR_SCALE_CLASS3: scale_ff[3] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_UPD;
         S_UPD:   state_in = S_MAP;
         S_MAP:   state_in = S_SCALE;
         S_SCALE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the request
   always_ff @(posedge clock) begin
      if (accept) begin
         cls_ff      <= req_ch.criticality_class;
         cnt_ff      <= req_ch.access_count;
         in_range_ff <= req_in_range;
      end
   end

   // Read the old count at accept, write the new one back in the update step
   always_comb begin
      mem_cmd.rd_en   = accept && req_in_range;
      mem_cmd.wr_en   = (state_ff == S_UPD) && in_range_ff;
      mem_cmd.addr    = (state_ff == S_IDLE) ? req_ch.criticality_class : cls_ff;
      mem_cmd.wr_data = cnt_ff;
   end

   cbb_count_store #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (mem_cmd),
      .old_count (old_count)
   );

   // Move the running total by the difference of new and old count
   assign total_in = total_ff + TOTAL_W'(cnt_ff) - TOTAL_W'(old_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (state_ff == S_UPD && in_range_ff) begin
         total_ff <= total_in;
      end
   end

   // Bucket multiply; the difference only matters inside the band
   assign diff = total_ff[DIFF_W-1:0] - LOW_EDGE[DIFF_W-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == S_MAP) begin
         prod_ff    <= PROD_W'(diff) * PROD_W'(BUCKET_MUL);
         le_low_ff  <= total_ff <= LOW_EDGE;
         ge_high_ff <= total_ff >= HIGH_EDGE;
      end
   end

   // Pick the bucket, clamp, and scale its budget
   always_comb begin
      raw_idx = prod_ff[PROD_W-1:PROD_W-BUCKET_IDX_W];
      if (le_low_ff) begin
         idx = '0;
      end else if (ge_high_ff || raw_idx > BUCKET_LAST) begin
         idx = BUCKET_LAST;
      end else begin
         idx = raw_idx;
      end
      scale_sel  = (cls_ff < CLASS_W'(NUM_SCALE)) ? scale_ff[cls_ff[1:0]] : scale_ff[3];
      scaled     = SCALED_W'(bucket_budget(idx)) * SCALED_W'(scale_sel);
      shifted    = scaled[SCALED_W-1:8];
      budget_sat = (shifted > (SCALED_W-8)'(BUDGET_MAX)) ? BUDGET_MAX
                                                          : shifted[BUDGET_W-1:0];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_SCALE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SCALE && rsp_free) begin
         rsp_bvalid_ff <= in_range_ff && (cls_ff != CLASS_TOP);
         rsp_budget_ff <= (in_range_ff && (cls_ff != CLASS_TOP)) ? budget_sat : '0;
         rsp_total_ff  <= total_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.next_budget  = rsp_budget_ff;
   assign rsp_ch.budget_valid = rsp_bvalid_ff;
   assign rsp_ch.system_total = rsp_total_ff;

   // Checks
`include "criticality_bandwidth_budget_top_assert.svh"

   `CBB_ASSERT_NEXT(a_total_holds_idle, (state_ff == S_IDLE) && !accept, $stable(total_ff))
   `CBB_ASSERT_IMP(a_no_budget_zero, rsp_valid_ff && !rsp_bvalid_ff, rsp_budget_ff == '0)
   `CBB_ASSERT_IMP(a_budget_capped, rsp_valid_ff, rsp_budget_ff <= BUDGET_MAX)
   `CBB_ASSERT_NEXT(a_accept_starts, accept, state_ff == S_UPD)

endmodule

@@ test/cbb_budget_checker.sv @@
// ---------------------------------------------------------------------------
// Criticality bandwidth budget checker
// Watches the request, result and register-write ports of the budget block,
// keeps its own copy of the class counts, running total and class scales,
// predicts one result per accepted request and compares each accepted
// result with the oldest outstanding prediction, field by field.
// ---------------------------------------------------------------------------
module cbb_budget_checker (
   input  logic                          clock,
   input  logic                          reset,
   cbb_req_if                            req_mon,
   cbb_rsp_if                            rsp_mon,
   input  logic                          csr_wr_en,
   input  logic [cbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cbb_pkg::SCALE_W-1:0]   csr_wr_data,
   output int unsigned                   mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cbb_pkg::*;

   localparam int HIGHEST_CLASS = NUM_CLASSES_DEF - 1;
   localparam int LAST_TIER     = NUM_BUCKETS_DEF - 1;
   localparam longint unsigned TOTAL_FLOOR   = 400;
   localparam longint unsigned TOTAL_CEILING = 100000;
   localparam longint unsigned TIER_SLOPE    = 388003;
   localparam longint unsigned GRANT_LIMIT   = 100000;

   typedef struct packed {
      logic [BUDGET_W-1:0] next_budget;
      logic                budget_valid;
      logic [TOTAL_W-1:0]  system_total;
   } budget_result_type;

   logic [COUNT_W-1:0] count_by_class [NUM_CLASSES_DEF];
   logic [TOTAL_W-1:0] total_accesses;
   logic [SCALE_W-1:0] class_scale [NUM_SCALE];
   budget_result_type  expected_budgets [$];

   // Unscaled budget of each tier; tiers past the tenth keep the smallest
   function automatic longint unsigned tier_budget(input longint unsigned tier);
      case (tier)
         0:       return 100000;
         1:       return 50000;
         2:       return 25000;
         3:       return 10000;
         4:       return 5000;
         5:       return 1000;
         6:       return 750;
         7:       return 500;
         8:       return 250;
         default: return 100;
      endcase
   endfunction

   // Map the system total to a tier and scale that tier's budget by Q8
   function automatic logic [BUDGET_W-1:0] scaled_grant(input logic [TOTAL_W-1:0] total,
                                                         input logic [SCALE_W-1:0] scale);
      longint unsigned tier;
      longint unsigned grant;
      if (64'(total) <= TOTAL_FLOOR)
         tier = 0;
      else if (64'(total) >= TOTAL_CEILING)
         tier = LAST_TIER;
      else
         tier = ((64'(total) - TOTAL_FLOOR) * TIER_SLOPE) >> 32;
      if (tier > LAST_TIER)
         tier = LAST_TIER;
      grant = (tier_budget(tier) * 64'(scale)) >> 8;
      if (grant > GRANT_LIMIT)
         grant = GRANT_LIMIT;
      return grant[BUDGET_W-1:0];
   endfunction

   // Replace the class count, move the total and work out the budget
   function automatic budget_result_type apply_count_report(input logic [CLASS_W-1:0] cls,
                                                            input logic [COUNT_W-1:0] accesses);
      budget_result_type res;
      res = '0;
      if (int'(cls) < NUM_CLASSES_DEF) begin
         total_accesses = total_accesses + TOTAL_W'(accesses)
                          - TOTAL_W'(count_by_class[cls]);
         count_by_class[cls] = accesses;
         if (int'(cls) != HIGHEST_CLASS) begin
            res.next_budget  = scaled_grant(total_accesses,
                                            class_scale[(cls < 3'd4) ? cls[1:0] : 2'd3]);
            res.budget_valid = 1'b1;
         end
      end
      res.system_total = total_accesses;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: budget mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Track writes, predict on each request, compare on each result
   always @(posedge clock) begin
      budget_result_type want;
      if (reset) begin
         foreach (count_by_class[i]) count_by_class[i] = '0;
         total_accesses = '0;
         class_scale[0] = 9'd64;
         class_scale[1] = 9'd128;
         class_scale[2] = 9'd192;
         class_scale[3] = 9'd256;
         expected_budgets.delete();
      end else begin
         if (csr_wr_en)
            class_scale[csr_index] = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_budgets.size() == 0) begin
               report_mismatch($sformatf("result with no request outstanding (budget %0d total %0d)",
                                         rsp_mon.next_budget, rsp_mon.system_total));
            end else begin
               want = expected_budgets.pop_front();
               if (rsp_mon.next_budget !== want.next_budget)
                  report_mismatch($sformatf("next_budget expected %0d got %0d",
                                            want.next_budget, rsp_mon.next_budget));
               if (rsp_mon.budget_valid !== want.budget_valid)
                  report_mismatch($sformatf("budget_valid expected %0d got %0d",
                                            want.budget_valid, rsp_mon.budget_valid));
               if (rsp_mon.system_total !== want.system_total)
                  report_mismatch($sformatf("system_total expected %0d got %0d",
                                            want.system_total, rsp_mon.system_total));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_budgets.push_back(apply_count_report(req_mon.criticality_class,
                                                          req_mon.access_count));
      end
   end

endmodule

@@ test/tb_criticality_bandwidth_budget_top.sv @@
// ---------------------------------------------------------------------------
// Criticality bandwidth budget testbench
// Drives count requests and scale register writes into the budget block with
// random gaps and result stalls, one long result hold-off, and several scale
// settings including zero, unity and oversized; the checker beside the block
// predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_criticality_bandwidth_budget_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cbb_pkg::*;

   localparam int NUM_PHASES      = 8;
   localparam int PHASE_REQUESTS  = 210;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 8;
   localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = '1;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SCALE_W-1:0]   csr_wr_data;
   int unsigned          mismatch_count;

   int req_gap_max = 12;
   int rsp_gap_max = 12;
   bit hold_off_req = 1'b0;
   int requests_sent = 0;
   int results_taken = 0;

   cbb_req_if req_ch ();
   cbb_rsp_if rsp_ch ();

   criticality_bandwidth_budget_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   cbb_budget_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one request after a random gap and hold it until taken
   task automatic offer_request(input logic [CLASS_W-1:0] cls,
                                input logic [COUNT_W-1:0] accesses);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.criticality_class <= cls;
      req_ch.access_count      <= accesses;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
   endtask

   // Drop valid and wait until every outstanding result has come back
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (requests_sent != results_taken) @(posedge clock);
   endtask

   task automatic write_scales(input logic [SCALE_W-1:0] s0, input logic [SCALE_W-1:0] s1,
                               input logic [SCALE_W-1:0] s2, input logic [SCALE_W-1:0] s3);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SCALE_CLASS0;
      csr_wr_data <= s0;
      @(posedge clock);
      csr_index   <= CSR_SCALE_CLASS1;
      csr_wr_data <= s1;
      @(posedge clock);
      csr_index   <= CSR_SCALE_CLASS2;
      csr_wr_data <= s2;
      @(posedge clock);
      csr_index   <= CSR_SCALE_CLASS3;
      csr_wr_data <= s3;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Favour zero, unity and oversized scales
   function automatic logic [SCALE_W-1:0] draw_scale();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 9'd0;
      if (r < 30) return 9'd256;
      if (r < 40) return 9'd511;
      if (r < 45) return 9'd1;
      return SCALE_W'($urandom_range(0, 511));
   endfunction

   function automatic logic [COUNT_W-1:0] COUNT_W_ALL(input int r);
      return COUNT_ALL_ONES - COUNT_W'(r % 4);
   endfunction

   // Mostly counts that keep the total within the tier range, some extremes
   function automatic logic [COUNT_W-1:0] draw_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return COUNT_W'($urandom_range(0, 600));
      if (r < 72) return COUNT_W'($urandom_range(0, 25000));
      if (r < 84) return COUNT_W'($urandom_range(0, 100000));
      if (r < 88) return 32'd0;
      if (r < 91) return COUNT_W'(1) << $urandom_range(0, 31);
      if (r < 94) return COUNT_W_ALL(r);
      return COUNT_W'($urandom());
   endfunction

   // Release ready after a random stall; take the one long hold-off on request
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         results_taken++;
      end
   end

   // End the run when nothing is accepted for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int r;
      req_ch.valid             <= 1'b0;
      req_ch.criticality_class <= '0;
      req_ch.access_count      <= '0;
      csr_wr_en                <= 1'b0;
      csr_index                <= CSR_SCALE_CLASS0;
      csr_wr_data              <= '0;
      reset                    <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Tier edges, highest class, classes out of range and the largest total
      offer_request(3'd0, 32'd0);
      offer_request(3'd0, 32'd400);
      offer_request(3'd0, 32'd401);
      offer_request(3'd1, 32'd11069);
      offer_request(3'd2, 32'd88529);
      offer_request(3'd3, 32'd1);
      offer_request(3'd4, COUNT_ALL_ONES);
      offer_request(3'd5, 32'd7);
      offer_request(3'd7, COUNT_ALL_ONES);
      for (int c = 0; c < 4; c++) offer_request(CLASS_W'(c), COUNT_ALL_ONES);
      for (int c = 0; c < 5; c++) offer_request(CLASS_W'(c), 32'd0);

      // Zero, oversized, unity and minimal scales at the lowest and a middle tier
      wait_for_results();
      write_scales(9'd0, 9'd511, 9'd256, 9'd1);
      for (int c = 0; c < 4; c++) offer_request(CLASS_W'(c), 32'd0);
      for (int c = 0; c < 4; c++) offer_request(CLASS_W'(c), 32'd7000);

      // Random phases, each from idle with fresh scales and its own pacing
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_results();
         write_scales(draw_scale(), draw_scale(), draw_scale(), draw_scale());
         case (phase % 4)
            0: begin req_gap_max = 12; rsp_gap_max = 12; end
            1: begin req_gap_max = 0;  rsp_gap_max = 0;  end
            2: begin req_gap_max = 12; rsp_gap_max = 0;  end
            default: begin req_gap_max = 0; rsp_gap_max = 12; end
         endcase
         if (phase == 1)
            hold_off_req = 1'b1;
         repeat (PHASE_REQUESTS) begin
            r = $urandom_range(0, 99);
            if (r < 6)
               offer_request(CLASS_W'($urandom_range(5, 7)), draw_count());
            else
               offer_request(CLASS_W'($urandom_range(0, 4)), draw_count());
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
